// ===== hdl/chull_pkg.sv =====
// Shared constants and control types for the monotone chain hull block.
package chull_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W        = 32;
    localparam int POINT_W        = 2 * COORD_W;

    // Store write data select codes
    localparam logic [1:0] WSEL_IN    = 2'd0;
    localparam logic [1:0] WSEL_RDATA = 2'd1;
    localparam logic [1:0] WSEL_KEY   = 2'd2;

    typedef struct packed {
        logic       st_we;      // write point store
        logic [1:0] st_wsel;    // point store write data select
        logic       st_re;      // read point store
        logic       sk_we;      // push b onto hull stack memory
        logic       sk_re;      // read hull stack memory
        logic       ld_key;     // latch sort key from store read data
        logic       ld_b;       // latch candidate point from store read data
        logic       ld_o;       // latch stack point and form differences
        logic       mul_p;      // first cross product term
        logic       mul_q;      // second cross product term
        logic       pop;        // top takes the latched stack point
        logic       push;       // top takes the candidate point
        logic       out_load;   // load result register
        logic       out_stack;  // result comes from stack memory
        logic       out_last;   // final vertex of the set
        logic       out_ovf;    // points were dropped in this set
    } cmd_t;

    typedef struct packed {
        logic less;      // sort key below store read data
        logic turn_le;   // cross product zero or negative
        logic out_busy;  // result register stays occupied
    } stat_t;

endpackage

// ===== hdl/chull_ram.sv =====
// Generic single write, single read RAM with registered read data.
module chull_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/chull_dp.sv =====
// Datapath: point store, hull stack, sort compare, cross product unit, result register.
module chull_dp #(
    parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  chull_pkg::cmd_t                       cmd,
    input  logic [$clog2(MAX_POINTS)-1:0]         st_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]         st_raddr,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       sk_waddr,
    input  logic [$clog2(MAX_POINTS+1)-1:0]       sk_raddr,
    input  logic signed [chull_pkg::COORD_W-1:0]  point_x,
    input  logic signed [chull_pkg::COORD_W-1:0]  point_y,
    output chull_pkg::stat_t                      stat,
    output logic signed [chull_pkg::COORD_W-1:0]  hull_x,
    output logic signed [chull_pkg::COORD_W-1:0]  hull_y,
    output logic                                  last_vertex,
    output logic                                  overflowed,
    output logic                                  out_valid,
    input  logic                                  out_stall
);
    import chull_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int PW = 2 * DW;

    logic [POINT_W-1:0] st_wdata;
    logic [POINT_W-1:0] st_rdata;
    logic [POINT_W-1:0] sk_rdata;

    logic [POINT_W-1:0] key_reg;
    logic [POINT_W-1:0] b_reg;
    logic [POINT_W-1:0] o_reg;
    logic [POINT_W-1:0] top_reg;

    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [PW-1:0] p_reg, q_reg;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    logic signed [COORD_W-1:0] kx, ky, rx, ry;
    logic signed [COORD_W-1:0] ox, oy;

    logic                      out_valid_reg;
    logic [COORD_W-1:0]        hull_x_reg, hull_y_reg;
    logic                      last_reg, ovf_reg;
    logic [POINT_W-1:0]        out_src;

    // Select point store write data
    always_comb
    begin
        case (cmd.st_wsel)
            WSEL_IN:    st_wdata = {point_x, point_y};
            WSEL_RDATA: st_wdata = st_rdata;
            WSEL_KEY:   st_wdata = key_reg;
            default:    st_wdata = key_reg;
        endcase
    end

    chull_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (cmd.st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    chull_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS + 1)) u_stack (
        .clk   (clk),
        .we    (cmd.sk_we),
        .waddr (sk_waddr),
        .wdata (b_reg),
        .re    (cmd.sk_re),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    // Sort order: x first, then y
    assign kx = $signed(key_reg[POINT_W-1:COORD_W]);
    assign ky = $signed(key_reg[COORD_W-1:0]);
    assign rx = $signed(st_rdata[POINT_W-1:COORD_W]);
    assign ry = $signed(st_rdata[COORD_W-1:0]);
    assign stat.less = (kx < rx) || ((kx == rx) && (ky < ry));

    // Hold sort key, candidate point, stack point and stack top
    always_ff @(posedge clk)
    begin
        if (cmd.ld_key)
        begin
            key_reg <= st_rdata;
        end
        if (cmd.ld_b)
        begin
            b_reg <= st_rdata;
        end
        if (cmd.ld_o)
        begin
            o_reg <= sk_rdata;
        end
        if (cmd.pop)
        begin
            top_reg <= o_reg;
        end
        else if (cmd.push)
        begin
            top_reg <= b_reg;
        end
    end

    // Differences against the point below the stack top
    assign ox = $signed(sk_rdata[POINT_W-1:COORD_W]);
    assign oy = $signed(sk_rdata[COORD_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.ld_o)
        begin
            ax_reg <= DW'($signed(top_reg[POINT_W-1:COORD_W])) - DW'(ox);
            ay_reg <= DW'($signed(top_reg[COORD_W-1:0])) - DW'(oy);
            bx_reg <= DW'($signed(b_reg[POINT_W-1:COORD_W])) - DW'(ox);
            by_reg <= DW'($signed(b_reg[COORD_W-1:0])) - DW'(oy);
        end
    end

    // One shared multiplier forms both cross product terms
    assign mul_a = cmd.mul_p ? ax_reg : ay_reg;
    assign mul_b = cmd.mul_p ? by_reg : bx_reg;
    assign prod  = PW'(mul_a) * PW'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_p)
        begin
            p_reg <= prod;
        end
        if (cmd.mul_q)
        begin
            q_reg <= prod;
        end
    end

    assign stat.turn_le = (p_reg <= q_reg);

    // Result register
    assign out_src       = cmd.out_stack ? sk_rdata : st_rdata;
    assign stat.out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hull_x_reg <= out_src[POINT_W-1:COORD_W];
            hull_y_reg <= out_src[COORD_W-1:0];
            last_reg   <= cmd.out_last;
            ovf_reg    <= cmd.out_ovf;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hull_x      = $signed(hull_x_reg);
    assign hull_y      = $signed(hull_y_reg);
    assign last_vertex = last_reg;
    assign overflowed  = ovf_reg;

endmodule

// ===== hdl/chull_ctrl.sv =====
// Controller: load, insertion sort, hull passes and emission sequencing.
module chull_ctrl #(
    parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              is_last,
    output logic                              in_stall,
    input  chull_pkg::stat_t                  stat,
    output chull_pkg::cmd_t                   cmd,
    output logic [$clog2(MAX_POINTS)-1:0]     st_waddr,
    output logic [$clog2(MAX_POINTS)-1:0]     st_raddr,
    output logic [$clog2(MAX_POINTS+1)-1:0]   sk_waddr,
    output logic [$clog2(MAX_POINTS+1)-1:0]   sk_raddr
);
    import chull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = $clog2(MAX_POINTS + 2);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_SORT_KEY  = 4'd1;
    localparam logic [3:0] S_SORT_KEYW = 4'd2;
    localparam logic [3:0] S_SORT_RD   = 4'd3;
    localparam logic [3:0] S_SORT_CMP  = 4'd4;
    localparam logic [3:0] S_SORT_PUT  = 4'd5;
    localparam logic [3:0] S_H_RDB     = 4'd6;
    localparam logic [3:0] S_H_LDB     = 4'd7;
    localparam logic [3:0] S_H_CHK     = 4'd8;
    localparam logic [3:0] S_H_LDO     = 4'd9;
    localparam logic [3:0] S_H_MP      = 4'd10;
    localparam logic [3:0] S_H_MQ      = 4'd11;
    localparam logic [3:0] S_H_DEC     = 4'd12;
    localparam logic [3:0] S_H_PUSH    = 4'd13;
    localparam logic [3:0] S_EM_RD     = 4'd14;
    localparam logic [3:0] S_EM_WR     = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] lower_reg, lower_next;
    logic          upper_reg, upper_next;
    logic          echo_reg, echo_next;
    logic [DW-1:0] k_reg, k_next;

    logic          accept;
    logic          full;
    logic [CW-1:0] n_new;
    logic          chk_ok;
    logic [DW-1:0] em_limit;
    logic          em_last;

    assign in_stall = (state_reg != S_LOAD);
    assign accept   = in_valid && (state_reg == S_LOAD);
    assign full     = (count_reg == CW'(MAX_POINTS));
    assign n_new    = full ? count_reg : count_reg + 1'b1;
    assign chk_ok   = upper_reg ? (depth_reg > lower_reg) : (depth_reg >= DW'(2));
    assign em_limit = echo_reg ? DW'(count_reg) : depth_reg;
    assign em_last  = ((k_reg + 1'b1) == em_limit);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        depth_next = depth_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        echo_next  = echo_reg;
        k_next     = k_reg;
        cmd        = '0;
        st_waddr   = '0;
        st_raddr   = '0;
        sk_waddr   = depth_reg[SW-1:0];
        sk_raddr   = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    // Store the point unless the store is full
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        cmd.st_we    = 1'b1;
                        cmd.st_wsel  = WSEL_IN;
                        st_waddr     = count_reg[AW-1:0];
                    end
                    count_next = n_new;
                    if (is_last)
                    begin
                        k_next = '0;
                        if (n_new < CW'(3))
                        begin
                            echo_next  = 1'b1;
                            state_next = S_EM_RD;
                        end
                        else
                        begin
                            echo_next  = 1'b0;
                            i_next     = CW'(1);
                            state_next = S_SORT_KEY;
                        end
                    end
                end
            end

            S_SORT_KEY:
            begin
                if (i_reg == count_reg)
                begin
                    // Sorted: start the lower hull
                    depth_next = '0;
                    i_next     = '0;
                    upper_next = 1'b0;
                    state_next = S_H_RDB;
                end
                else
                begin
                    cmd.st_re  = 1'b1;
                    st_raddr   = i_reg[AW-1:0];
                    j_next     = i_reg;
                    state_next = S_SORT_KEYW;
                end
            end

            S_SORT_KEYW:
            begin
                cmd.ld_key = 1'b1;
                state_next = S_SORT_RD;
            end

            S_SORT_RD:
            begin
                cmd.st_re  = 1'b1;
                st_raddr   = AW'(j_reg - 1'b1);
                state_next = S_SORT_CMP;
            end

            S_SORT_CMP:
            begin
                if (stat.less)
                begin
                    // Shift the larger point up one slot
                    cmd.st_we   = 1'b1;
                    cmd.st_wsel = WSEL_RDATA;
                    st_waddr    = j_reg[AW-1:0];
                    j_next      = j_reg - 1'b1;
                    state_next  = (j_reg == CW'(1)) ? S_SORT_PUT : S_SORT_RD;
                end
                else
                begin
                    state_next = S_SORT_PUT;
                end
            end

            S_SORT_PUT:
            begin
                cmd.st_we   = 1'b1;
                cmd.st_wsel = WSEL_KEY;
                st_waddr    = j_reg[AW-1:0];
                i_next      = i_reg + 1'b1;
                state_next  = S_SORT_KEY;
            end

            S_H_RDB:
            begin
                cmd.st_re  = 1'b1;
                st_raddr   = i_reg[AW-1:0];
                state_next = S_H_LDB;
            end

            S_H_LDB:
            begin
                cmd.ld_b   = 1'b1;
                state_next = S_H_CHK;
            end

            S_H_CHK:
            begin
                if (chk_ok)
                begin
                    cmd.sk_re  = 1'b1;
                    sk_raddr   = SW'(depth_reg - DW'(2));
                    state_next = S_H_LDO;
                end
                else
                begin
                    state_next = S_H_PUSH;
                end
            end

            S_H_LDO:
            begin
                cmd.ld_o   = 1'b1;
                state_next = S_H_MP;
            end

            S_H_MP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = S_H_MQ;
            end

            S_H_MQ:
            begin
                cmd.mul_q  = 1'b1;
                state_next = S_H_DEC;
            end

            S_H_DEC:
            begin
                if (stat.turn_le)
                begin
                    // Drop the top vertex and test again
                    cmd.pop    = 1'b1;
                    depth_next = depth_reg - 1'b1;
                    state_next = S_H_CHK;
                end
                else
                begin
                    state_next = S_H_PUSH;
                end
            end

            S_H_PUSH:
            begin
                cmd.sk_we  = 1'b1;
                cmd.push   = 1'b1;
                depth_next = depth_reg + 1'b1;
                state_next = S_H_RDB;
                if (!upper_reg)
                begin
                    if ((i_reg + 1'b1) == count_reg)
                    begin
                        // Lower hull done: walk back for the upper hull
                        lower_next = depth_reg + 1'b1;
                        upper_next = 1'b1;
                        i_next     = count_reg - CW'(2);
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else if (i_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    i_next = i_reg - 1'b1;
                end
            end

            S_EM_RD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.st_re  = echo_reg;
                    cmd.sk_re  = !echo_reg;
                    st_raddr   = k_reg[AW-1:0];
                    sk_raddr   = k_reg[SW-1:0];
                    state_next = S_EM_WR;
                end
            end

            S_EM_WR:
            begin
                cmd.out_load  = 1'b1;
                cmd.out_stack = !echo_reg;
                cmd.out_last  = em_last;
                cmd.out_ovf   = drop_reg;
                k_next        = k_reg + 1'b1;
                if (em_last)
                begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    depth_next = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_EM_RD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            depth_reg <= '0;
            lower_reg <= '0;
            upper_reg <= 1'b0;
            echo_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            depth_reg <= depth_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            echo_reg  <= echo_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== hdl/convex_hull_monotone_chain.sv =====
// Flow: points load one per cycle while in_stall is low; a closing point starts the in-place
// insertion sort, then the lower and upper hull passes, whose stack tests share one multiplier,
// then the vertices are emitted; a set of fewer than three points is emitted unchanged.
// Output: a vertex waits until the one before is taken; the next set loads after the last vertex.
// Reset: asynchronous active low; clears the controller and result valid, memories are not cleared.
// Top level of the monotone chain convex hull block.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [chull_pkg::COORD_W-1:0]  point_x,
    input  logic signed [chull_pkg::COORD_W-1:0]  point_y,
    input  logic                                  is_last,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [chull_pkg::COORD_W-1:0]  hull_x,
    output logic signed [chull_pkg::COORD_W-1:0]  hull_y,
    output logic                                  last_vertex,
    output logic                                  overflowed
);
    import chull_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(MAX_POINTS + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] sk_waddr, sk_raddr;

    chull_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .is_last  (is_last),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd),
        .st_waddr (st_waddr),
        .st_raddr (st_raddr),
        .sk_waddr (sk_waddr),
        .sk_raddr (sk_raddr)
    );

    chull_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st_waddr    (st_waddr),
        .st_raddr    (st_raddr),
        .sk_waddr    (sk_waddr),
        .sk_raddr    (sk_raddr),
        .point_x     (point_x),
        .point_y     (point_y),
        .stat        (stat),
        .hull_x      (hull_x),
        .hull_y      (hull_y),
        .last_vertex (last_vertex),
        .overflowed  (overflowed),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule

// ===== hdl/chull_chk.sv =====
// Port checker for the convex hull block, bound to the top level.
module chull_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  is_last,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [chull_pkg::COORD_W-1:0]  hull_x,
    input logic signed [chull_pkg::COORD_W-1:0]  hull_y,
    input logic                                  last_vertex
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hull_x) && $stable(hull_y))
        else $error("stalled result changed");

    // Closing a set blocks further input
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_last |=> in_stall)
        else $error("input taken right after set closed");

    // Input stays blocked while a hull is still being emitted
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_vertex |-> in_stall)
        else $error("input open during hull emission");

    // No result appears right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind convex_hull_monotone_chain chull_chk u_chull_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hull_x      (hull_x),
    .hull_y      (hull_y),
    .last_vertex (last_vertex)
);
